// ===== rtl/ssclk_pkg.sv =====
package ssclk_pkg;

	localparam int LINE_DEPTH = 16;
	localparam int LEN_W = $clog2(LINE_DEPTH);
	localparam int HELD_BYTES = 7;

	localparam logic [1:0] REQ_BYTE = 2'd0;
	localparam logic [1:0] REQ_SECOND = 2'd1;
	localparam logic [1:0] REQ_SCAN = 2'd2;

	localparam logic [1:0] KIND_REPLY = 2'd0;
	localparam logic [1:0] KIND_TIME = 2'd1;
	localparam logic [1:0] KIND_SCAN = 2'd2;

	localparam logic [1:0] REPLY_OK = 2'd0;
	localparam logic [1:0] REPLY_ERR = 2'd1;
	localparam logic [1:0] REPLY_UNKNOWN = 2'd2;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_H = 8'h48;
	localparam logic [7:0] CHAR_M = 8'h4D;
	localparam logic [7:0] CHAR_S = 8'h53;
	localparam logic [7:0] CHAR_T = 8'h54;
	localparam logic [7:0] CHAR_ZERO = 8'h30;

	localparam logic [7:0] DASH_PATTERN = 8'hBF;
	localparam logic [7:0] BLANK_PATTERN = 8'hFF;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] rx_byte;
	} req_item_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [1:0] reply_code;
		logic [4:0] report_hours;
		logic [5:0] report_minutes;
		logic [5:0] report_seconds;
		logic [7:0] segment_pattern;
		logic [7:0] digit_select;
	} res_item_t;

	function automatic logic [7:0] digit_glyph(input logic [3:0] d);
		logic [7:0] g;
		case (d)
			4'd0: g = 8'hC0;
			4'd1: g = 8'hF9;
			4'd2: g = 8'hA4;
			4'd3: g = 8'hB0;
			4'd4: g = 8'h99;
			4'd5: g = 8'h92;
			4'd6: g = 8'h82;
			4'd7: g = 8'hF8;
			4'd8: g = 8'h80;
			4'd9: g = 8'h90;
			default: g = 8'hC0;
		endcase
		return g;
	endfunction

	function automatic logic [3:0] tens_of(input logic [5:0] v);
		logic [3:0] t;
		if (v >= 6'd50) t = 4'd5;
		else if (v >= 6'd40) t = 4'd4;
		else if (v >= 6'd30) t = 4'd3;
		else if (v >= 6'd20) t = 4'd2;
		else if (v >= 6'd10) t = 4'd1;
		else t = 4'd0;
		return t;
	endfunction

	function automatic logic [3:0] units_of(input logic [5:0] v);
		logic [5:0] tens10;
		logic [5:0] u;
		tens10 = 6'({tens_of(v), 1'b0} + {tens_of(v), 3'b000});
		u = v - tens10;
		return u[3:0];
	endfunction

	function automatic logic [7:0] two_digit(input logic [7:0] d1, input logic [7:0] d2);
		logic [7:0] hi;
		logic [7:0] lo;
		hi = d1 - CHAR_ZERO;
		lo = d2 - CHAR_ZERO;
		return {hi[4:0], 3'b000} + {hi[6:0], 1'b0} + lo;
	endfunction

endpackage

// ===== rtl/serial_set_clock_with_segment_scan.sv =====
// An accepted item is registered in the input stage and its result in the result register.
// Throughput: one item per cycle unless stalled; these registers decouple the ports.
// A stalled result holds the input stage only when the waiting item itself gives a result.
// Reset clears the time to 00:00:00, empties the line, restarts the scan at the seconds
// digit and blanks the display until the first tick or accepted set command.
module serial_set_clock_with_segment_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  ssclk_pkg::req_item_t  req,
	output logic                  res_valid,
	input  logic                  res_stall,
	output ssclk_pkg::res_item_t  res
);
	import ssclk_pkg::*;

	localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_DEPTH - 1);
	localparam logic [LEN_W-1:0] LEN_SHORT = LEN_W'(3);
	localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(HELD_BYTES);

	logic        in_valid_s1;
	req_item_t   in_item_s1;
	logic        res_valid_q;
	res_item_t   res_q;

	logic [4:0]       hours_q;
	logic [5:0]       minutes_q;
	logic [5:0]       seconds_q;
	logic [LEN_W-1:0] line_len_q;
	logic [7:0]       line_q [HELD_BYTES];
	logic [2:0]       scan_pos_q;
	logic             loaded_q;

	logic             has_result;
	res_item_t        res_next;
	logic [4:0]       hours_d;
	logic [5:0]       minutes_d;
	logic [5:0]       seconds_d;
	logic [LEN_W-1:0] line_len_d;
	logic [2:0]       scan_pos_d;
	logic             loaded_d;
	logic             store_byte;
	logic             res_free;
	logic             advance;
	logic             fire;
	logic [7:0]       val_a;
	logic [7:0]       val_b;
	logic [7:0]       val_c;
	logic [7:0]       glyph;

	assign res_free = !res_valid_q || !res_stall;
	assign advance = res_free || !has_result;
	assign fire = in_valid_s1 && advance;
	assign req_stall = in_valid_s1 && !advance;
	assign res_valid = res_valid_q;
	assign res = res_q;

	assign val_a = two_digit(line_q[1], line_q[2]);
	assign val_b = two_digit(line_q[3], line_q[4]);
	assign val_c = two_digit(line_q[5], line_q[6]);

	always_comb begin
		glyph = DASH_PATTERN;
		case (scan_pos_q)
			3'd7: glyph = digit_glyph(tens_of({1'b0, hours_q}));
			3'd6: glyph = digit_glyph(units_of({1'b0, hours_q}));
			3'd4: glyph = digit_glyph(tens_of(minutes_q));
			3'd3: glyph = digit_glyph(units_of(minutes_q));
			3'd1: glyph = digit_glyph(tens_of(seconds_q));
			3'd0: glyph = digit_glyph(units_of(seconds_q));
			default: glyph = DASH_PATTERN;
		endcase
		if (!loaded_q) begin
			glyph = BLANK_PATTERN;
		end
	end

	always_comb begin
		has_result = 1'b0;
		res_next = '0;
		hours_d = hours_q;
		minutes_d = minutes_q;
		seconds_d = seconds_q;
		line_len_d = line_len_q;
		scan_pos_d = scan_pos_q;
		loaded_d = loaded_q;
		store_byte = 1'b0;
		unique case (in_item_s1.req_type)
			REQ_BYTE: begin
				if (in_item_s1.rx_byte == CHAR_CR || in_item_s1.rx_byte == CHAR_LF) begin
					line_len_d = '0;
					if (line_len_q != '0) begin
						has_result = 1'b1;
						res_next.result_kind = KIND_REPLY;
						if ((line_q[0] == CHAR_H || line_q[0] == CHAR_M ||
								line_q[0] == CHAR_S) && line_len_q >= LEN_SHORT) begin
							if (line_q[0] == CHAR_H) begin
								if (val_a >= 8'd24) begin
									res_next.reply_code = REPLY_ERR;
								end else begin
									res_next.reply_code = REPLY_OK;
									hours_d = val_a[4:0];
									loaded_d = 1'b1;
								end
							end else if (val_a >= 8'd60) begin
								res_next.reply_code = REPLY_ERR;
							end else begin
								res_next.reply_code = REPLY_OK;
								loaded_d = 1'b1;
								if (line_q[0] == CHAR_M) begin
									minutes_d = val_a[5:0];
								end else begin
									seconds_d = val_a[5:0];
								end
							end
						end else if (line_q[0] == CHAR_T && line_len_q >= LEN_FULL) begin
							if (val_a >= 8'd24 || val_b >= 8'd60 || val_c >= 8'd60) begin
								res_next.reply_code = REPLY_ERR;
							end else begin
								res_next.reply_code = REPLY_OK;
								hours_d = val_a[4:0];
								minutes_d = val_b[5:0];
								seconds_d = val_c[5:0];
								loaded_d = 1'b1;
							end
						end else begin
							res_next.reply_code = REPLY_UNKNOWN;
						end
					end
				end else begin
					store_byte = 1'b1;
					if (line_len_q != LEN_LAST) begin
						line_len_d = line_len_q + LEN_W'(1);
					end
				end
			end
			REQ_SECOND: begin
				has_result = 1'b1;
				loaded_d = 1'b1;
				if (seconds_q != 6'd59) begin
					seconds_d = seconds_q + 6'd1;
				end else begin
					seconds_d = '0;
					if (minutes_q != 6'd59) begin
						minutes_d = minutes_q + 6'd1;
					end else begin
						minutes_d = '0;
						hours_d = (hours_q == 5'd23) ? 5'd0 : hours_q + 5'd1;
					end
				end
				res_next.result_kind = KIND_TIME;
				res_next.report_hours = hours_d;
				res_next.report_minutes = minutes_d;
				res_next.report_seconds = seconds_d;
			end
			REQ_SCAN: begin
				has_result = 1'b1;
				res_next.result_kind = KIND_SCAN;
				res_next.segment_pattern = glyph;
				res_next.digit_select = 8'd1 << scan_pos_q;
				scan_pos_d = scan_pos_q + 3'd1;
			end
			default: begin
				has_result = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
			hours_q <= '0;
			minutes_q <= '0;
			seconds_q <= '0;
			line_len_q <= '0;
			scan_pos_q <= '0;
			loaded_q <= 1'b0;
		end else begin
			if (!req_stall) begin
				in_valid_s1 <= req_valid;
			end
			if (res_free) begin
				res_valid_q <= fire && has_result;
			end
			if (fire) begin
				hours_q <= hours_d;
				minutes_q <= minutes_d;
				seconds_q <= seconds_d;
				line_len_q <= line_len_d;
				scan_pos_q <= scan_pos_d;
				loaded_q <= loaded_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			in_item_s1 <= req;
		end
		if (res_free && fire && has_result) begin
			res_q <= res_next;
		end
		for (int i = 0; i < HELD_BYTES; i++) begin
			if (fire && store_byte && line_len_q == LEN_W'(i)) begin
				line_q[i] <= in_item_s1.rx_byte;
			end
		end
	end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import ssclk_pkg::*;

	localparam logic [79:0] GLYPH_ROM = {8'h90, 8'h80, 8'hF8, 8'h82, 8'h92,
		8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0};
	localparam int RANDOM_ITEMS = 1550;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_item_t req = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_item_t res;

	req_item_t pending_items[$];
	res_item_t expected_results[$];
	res_item_t want;

	logic [16:0] clock_secs;
	logic [LEN_W-1:0] line_len;
	logic [7:0] line_buf [LINE_DEPTH];
	logic [2:0] scan_pos;
	logic shown;

	int stim_count = 0;
	int total_items = 0;
	int accepted_count = 0;
	int mismatches = 0;
	int n_ok = 0;
	int n_err = 0;
	int n_unknown = 0;
	int n_reports = 0;
	int n_scans = 0;

	serial_set_clock_with_segment_scan DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always #2 clk = ~clk;

	function automatic logic [7:0] glyph(int d);
		return GLYPH_ROM[d*8 +: 8];
	endfunction

	function automatic int pair_value(int first);
		logic [7:0] v;
		v = (line_buf[first] - 8'd48) * 8'd10 + (line_buf[first+1] - 8'd48);
		return int'(v);
	endfunction

	task automatic predict_item(input req_item_t it);
		res_item_t r;
		int hh, mm, ss, vh, vm, vs, len, limit;
		logic [7:0] cmd;
		bit gives;
		r = '0;
		gives = 1'b0;
		hh = clock_secs / 3600;
		mm = (clock_secs % 3600) / 60;
		ss = clock_secs % 60;
		case (it.req_type)
			REQ_BYTE: begin
				if (it.rx_byte == CHAR_CR || it.rx_byte == CHAR_LF) begin
					len = int'(line_len);
					line_len = '0;
					if (len != 0) begin
						gives = 1'b1;
						r.result_kind = KIND_REPLY;
						r.reply_code = REPLY_UNKNOWN;
						cmd = line_buf[0];
						if ((cmd == CHAR_H || cmd == CHAR_M || cmd == CHAR_S) && len >= 3) begin
							vh = pair_value(1);
							limit = (cmd == CHAR_H) ? 24 : 60;
							if (vh < limit) begin
								r.reply_code = REPLY_OK;
								if (cmd == CHAR_H) hh = vh;
								else if (cmd == CHAR_M) mm = vh;
								else ss = vh;
							end else begin
								r.reply_code = REPLY_ERR;
							end
						end else if (cmd == CHAR_T && len >= 7) begin
							vh = pair_value(1);
							vm = pair_value(3);
							vs = pair_value(5);
							if (vh < 24 && vm < 60 && vs < 60) begin
								r.reply_code = REPLY_OK;
								hh = vh;
								mm = vm;
								ss = vs;
							end else begin
								r.reply_code = REPLY_ERR;
							end
						end
						if (r.reply_code == REPLY_OK) begin
							clock_secs = 17'(hh * 3600 + mm * 60 + ss);
							shown = 1'b1;
						end
					end
				end else begin
					line_buf[line_len] = it.rx_byte;
					if (line_len < LINE_DEPTH - 1) line_len = line_len + 1'b1;
				end
			end
			REQ_SECOND: begin
				clock_secs = (clock_secs == 17'd86399) ? 17'd0 : clock_secs + 17'd1;
				shown = 1'b1;
				gives = 1'b1;
				r.result_kind = KIND_TIME;
				r.report_hours = 5'(clock_secs / 3600);
				r.report_minutes = 6'((clock_secs % 3600) / 60);
				r.report_seconds = 6'(clock_secs % 60);
			end
			REQ_SCAN: begin
				gives = 1'b1;
				r.result_kind = KIND_SCAN;
				r.digit_select = 8'd1 << scan_pos;
				if (!shown) begin
					r.segment_pattern = BLANK_PATTERN;
				end else begin
					case (scan_pos)
						3'd7: r.segment_pattern = glyph(hh / 10);
						3'd6: r.segment_pattern = glyph(hh % 10);
						3'd4: r.segment_pattern = glyph(mm / 10);
						3'd3: r.segment_pattern = glyph(mm % 10);
						3'd1: r.segment_pattern = glyph(ss / 10);
						3'd0: r.segment_pattern = glyph(ss % 10);
						default: r.segment_pattern = DASH_PATTERN;
					endcase
				end
				scan_pos = scan_pos + 3'd1;
			end
			default: ;
		endcase
		if (gives) expected_results.push_back(r);
	endtask

	function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
		end
	endfunction

	function automatic int idle_pct(bit receiver);
		int phase;
		phase = (total_items == 0) ? 0 : accepted_count * 4 / total_items;
		case (phase)
			1: return receiver ? 0 : 79;
			2: return receiver ? 79 : 0;
			3: return 31;
			default: return 0;
		endcase
	endfunction

	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		while (b == CHAR_CR || b == CHAR_LF) b = 8'($urandom_range(0, 255));
		return b;
	endfunction

	task automatic push_item(input logic [1:0] kind, input logic [7:0] b);
		req_item_t it;
		it.req_type = kind;
		it.rx_byte = b;
		pending_items.push_back(it);
		if (kind != REQ_UNUSED) stim_count++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) push_item(REQ_BYTE, s[i]);
	endtask

	task automatic push_pair(input int v);
		push_item(REQ_BYTE, 8'(CHAR_ZERO + v / 10));
		push_item(REQ_BYTE, 8'(CHAR_ZERO + v % 10));
	endtask

	task automatic add_command();
		logic [7:0] cmd;
		int pick, nvals, shown_len, extras;
		logic [7:0] body[$];
		pick = $urandom_range(0, 9);
		if (pick < 2) cmd = CHAR_H;
		else if (pick < 4) cmd = CHAR_M;
		else if (pick < 6) cmd = CHAR_S;
		else if (pick < 9) cmd = CHAR_T;
		else cmd = text_byte();
		body.push_back(cmd);
		nvals = (cmd == CHAR_T) ? 3 : 1;
		if (cmd == CHAR_T && $urandom_range(0, 3) == 0) begin
			body.push_back("2"); body.push_back("3");
			body.push_back("5"); body.push_back("9");
			body.push_back("5"); body.push_back(8'(CHAR_ZERO + $urandom_range(5, 9)));
		end else begin
			for (int k = 0; k < nvals; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					if (cmd == CHAR_H || (cmd == CHAR_T && k == 0)) pick = $urandom_range(0, 23);
					else pick = $urandom_range(0, 59);
					body.push_back(8'(CHAR_ZERO + pick / 10));
					body.push_back(8'(CHAR_ZERO + pick % 10));
				end else if (pick < 85) begin
					pick = $urandom_range(0, 99);
					body.push_back(8'(CHAR_ZERO + pick / 10));
					body.push_back(8'(CHAR_ZERO + pick % 10));
				end else begin
					body.push_back(text_byte());
					body.push_back(text_byte());
				end
			end
		end
		shown_len = body.size();
		if ($urandom_range(0, 7) == 0) shown_len = $urandom_range(1, body.size() - 1);
		extras = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : 0;
		for (int k = 0; k < shown_len; k++) push_item(REQ_BYTE, body[k]);
		for (int k = 0; k < extras; k++) push_item(REQ_BYTE, text_byte());
		push_item(REQ_BYTE, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				predict_item(req);
				accepted_count++;
			end
			if (!req_valid || !req_stall) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
					req <= pending_items.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, actual %h", $time, res);
				end else begin
					want = expected_results.pop_front();
					check_field("result_kind", 8'(want.result_kind), 8'(res.result_kind));
					check_field("reply_code", 8'(want.reply_code), 8'(res.reply_code));
					check_field("report_hours", 8'(want.report_hours), 8'(res.report_hours));
					check_field("report_minutes", 8'(want.report_minutes),
						8'(res.report_minutes));
					check_field("report_seconds", 8'(want.report_seconds),
						8'(res.report_seconds));
					check_field("segment_pattern", want.segment_pattern, res.segment_pattern);
					check_field("digit_select", want.digit_select, res.digit_select);
				end
				case (res.result_kind)
					KIND_REPLY: begin
						if (res.reply_code == REPLY_OK) n_ok++;
						else if (res.reply_code == REPLY_ERR) n_err++;
						else n_unknown++;
					end
					KIND_TIME: n_reports++;
					default: n_scans++;
				endcase
			end
			res_stall <= ($urandom_range(0, 99) < idle_pct(1'b1));
		end
	end

	initial begin
		int pick;
		clock_secs = '0;
		line_len = '0;
		scan_pos = '0;
		shown = 1'b0;

		push_item(REQ_SCAN, 8'h00);
		push_item(REQ_SCAN, 8'h00);
		push_item(REQ_BYTE, CHAR_CR);
		push_item(REQ_UNUSED, 8'hFF);
		push_item(REQ_BYTE, 8'h00);
		push_item(REQ_BYTE, CHAR_LF);
		push_text("T235959");
		push_item(REQ_BYTE, CHAR_CR);
		push_item(REQ_SECOND, 8'h00);
		push_text("H24");
		push_item(REQ_BYTE, CHAR_LF);
		push_text("S6");
		push_item(REQ_BYTE, CHAR_CR);
		push_item(REQ_SCAN, 8'h00);

		pick = stim_count + RANDOM_ITEMS;
		while (stim_count < pick) begin
			case ($urandom_range(0, 99)) inside
				[0:34]: add_command();
				[35:59]: push_item(REQ_SECOND, 8'($urandom_range(0, 255)));
				[60:84]: push_item(REQ_SCAN, 8'($urandom_range(0, 255)));
				[85:95]: push_item(REQ_BYTE, 8'($urandom_range(0, 255)));
				default: push_item(REQ_UNUSED, 8'($urandom_range(0, 255)));
			endcase
		end
		total_items = pending_items.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || req_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d items; command replies: %0d OK, %0d ERR, %0d unknown.",
			accepted_count, n_ok, n_err, n_unknown);
		$display("Checked %0d time reports and %0d scan outputs, %0d mismatches.",
			n_reports, n_scans, mismatches);
		if (mismatches == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("Run timed out.");
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
